[hw/rtl/sgm_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Shared widths, register indexes, reset values and item types.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration port.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

  // Wide enough for any frame dimension up to the largest supported maximum.
  localparam int DIM_W = 14;

  // Datapath widths.
  localparam int PIX_W  = 8;
  localparam int MAG_W  = 11;
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int SUM_W  = 21;

  // Queue depths.
  localparam int OP_DEPTH  = 4;
  localparam int OUT_DEPTH = 32;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel;
  } sample_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             row_last;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic row_last;
    logic frame_last;
  } res_tag_t;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    logic             row_end;    // emit the last result of the previous row
    logic             frame_end;  // final drain item of the frame
    logic             mid_res;    // emit the result of the window centre
    logic             win_clear;  // start of a row: window restarts from zero
    logic             shift;      // a new column enters the window and the line stores
    logic             top_en;     // upper line store holds a row of this frame
    logic             mid_en;     // middle line store holds a row of this frame
    logic [PIX_W-1:0] bot;        // new bottom sample, zero outside the frame
  } op_t;

endpackage

[hw/rtl/sgm_fifo.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude queue
// Small register queue with a level count, used on both sides of the back end.
// ----------------------------------------------------------------------------
module sgm_fifo #(
  parameter int WIDTH = $bits(sgm_pkg::result_t),
  parameter int DEPTH = sgm_pkg::OP_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic                       full,
  output logic                       empty
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  level;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + CNTW'(1);
      end else if (pop && !push) begin
        level <= level - CNTW'(1);
      end
    end
  end

  assign pop_data = slots[rd_ptr];
  assign count    = level;
  assign full     = (level == CNTW'(DEPTH));
  assign empty    = (level == '0);

endmodule

[hw/rtl/sgm_front.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude front end
// Holds the frame registers and the raster position, and classifies each item.
// ----------------------------------------------------------------------------
module sgm_front #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               accept,
  input  sgm_pkg::sample_t                   sample,
  output sgm_pkg::op_t                       op,
  output logic [$clog2(MAX_WIDTH)-1:0]       op_addr
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int DW = sgm_pkg::DIM_W;

  logic [sgm_pkg::CFG_W-1:0] frame_width;
  logic [sgm_pkg::CFG_W-1:0] frame_height;
  logic [CW-1:0]             col;
  logic [CW-1:0]             col_next;
  logic [RW-1:0]             row;
  logic [RW-1:0]             row_next;

  logic [DW-1:0] w_ext;
  logic [DW-1:0] h_ext;
  logic [DW-1:0] w_lim;
  logic [DW-1:0] h_lim;
  logic [CW-1:0] w_c;
  logic [RW-1:0] h_c;
  logic [RW-1:0] h_p1;
  logic [CW-1:0] col_a;
  logic [CW-1:0] col_b;
  logic [CW-1:0] col_inc;
  logic [RW-1:0] row_a;
  logic [RW-1:0] row_b;
  logic          drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sgm_pkg::FRAME_WIDTH_RESET;
      frame_height <= sgm_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgm_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        sgm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  // Effective dimensions: zero acts as one, and values above the maximum saturate.
  always_comb begin
    w_ext = DW'(frame_width);
    h_ext = DW'(frame_height);
    if (w_ext == '0) begin
      w_lim = DW'(1);
    end else if (w_ext > DW'(MAX_WIDTH)) begin
      w_lim = DW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    if (h_ext == '0) begin
      h_lim = DW'(1);
    end else if (h_ext > DW'(MAX_HEIGHT)) begin
      h_lim = DW'(MAX_HEIGHT);
    end else begin
      h_lim = h_ext;
    end
    w_c  = w_lim[CW-1:0];
    h_c  = h_lim[RW-1:0];
    h_p1 = h_c + RW'(1);
  end

  always_comb begin
    // A column beyond a narrowed width wraps to the next row.
    if (col >= w_c) begin
      col_a = '0;
      row_a = row + RW'(1);
    end else begin
      col_a = col;
      row_a = row;
    end
    // Anything at or past the drain point becomes the final drain item.
    if (row_a > h_p1 || (row_a == h_p1 && col_a != '0)) begin
      col_b = '0;
      row_b = h_p1;
    end else begin
      col_b = col_a;
      row_b = row_a;
    end
    drain = (row_b == h_p1);

    op.row_end   = (col_b == '0) && (row_b >= RW'(2));
    op.frame_end = drain;
    op.mid_res   = (col_b != '0) && (row_b != '0);
    op.win_clear = (col_b == '0);
    op.shift     = !drain;
    op.top_en    = (row_b >= RW'(2));
    op.mid_en    = (row_b != '0);
    op.bot       = (!sample.cmd && row_b < h_c) ? sample.pixel : '0;
    op_addr      = col_b[AW-1:0];

    col_inc = col_b + CW'(1);
    if (drain) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_c) begin
      col_next = '0;
      row_next = row_b + RW'(1);
    end else begin
      col_next = col_inc;
      row_next = row_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

[hw/rtl/sgm_isqrt.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sgm_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [sgm_pkg::SUM_W-1:0]  radicand,
  input  sgm_pkg::res_tag_t          in_tag,
  output logic                       out_valid,
  output logic [sgm_pkg::MAG_W-1:0]  root,
  output sgm_pkg::res_tag_t          out_tag
);

  localparam int STAGES = sgm_pkg::MAG_W;
  localparam int RAD_W  = 2 * STAGES;
  localparam int REM_W  = STAGES + 3;

  logic [STAGES-1:0]  v_q;
  logic [STAGES-1:0]  v_n;
  logic [REM_W-1:0]   rem_q  [STAGES];
  logic [REM_W-1:0]   rem_n  [STAGES];
  logic [STAGES-1:0]  root_q [STAGES];
  logic [STAGES-1:0]  root_n [STAGES];
  logic [RAD_W-1:0]   val_q  [STAGES];
  logic [RAD_W-1:0]   val_n  [STAGES];
  sgm_pkg::res_tag_t  tag_q  [STAGES];
  sgm_pkg::res_tag_t  tag_n  [STAGES];

  // Each stage brings down the next two radicand bits and decides one root bit.
  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [STAGES-1:0] root_in;
    logic [RAD_W-1:0]  val_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        rem_in   = '0;
        root_in  = '0;
        val_in   = RAD_W'(radicand);
        v_n[i]   = in_valid;
        tag_n[i] = in_tag;
      end else begin
        rem_in   = rem_q[i-1];
        root_in  = root_q[i-1];
        val_in   = val_q[i-1];
        v_n[i]   = v_q[i-1];
        tag_n[i] = tag_q[i-1];
      end
      rem_sh = {rem_in[REM_W-3:0], val_in[RAD_W-1 -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_n[i]  = rem_sh - trial;
        root_n[i] = {root_in[STAGES-2:0], 1'b1};
      end else begin
        rem_n[i]  = rem_sh;
        root_n[i] = {root_in[STAGES-2:0], 1'b0};
      end
      val_n[i] = {val_in[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      v_q <= v_n;
    end
  end

  always_ff @(posedge clk) begin
    rem_q  <= rem_n;
    root_q <= root_n;
    val_q  <= val_n;
    tag_q  <= tag_n;
  end

  assign out_valid = v_q[STAGES-1];
  assign root      = root_q[STAGES-1];
  assign out_tag   = tag_q[STAGES-1];

endmodule

[hw/rtl/sgm_back.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude back end
// Line stores, 3x3 window, gradients, squares and the square root pipeline.
// ----------------------------------------------------------------------------
module sgm_back #(
  parameter int MAX_WIDTH = sgm_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  input  sgm_pkg::op_t                   op,
  input  logic [$clog2(MAX_WIDTH)-1:0]   op_addr,
  input  logic                           credit_ok,
  output logic                           op_pop,
  output logic                           res_valid,
  output sgm_pkg::result_t               res
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int PW  = sgm_pkg::PIX_W;
  localparam int GW  = sgm_pkg::GRAD_W;
  localparam int WSW = PW + 2;

  typedef struct packed {
    logic [PW-1:0] top;
    logic [PW-1:0] mid;
    logic [PW-1:0] bot;
  } pcol_t;

  function automatic logic [WSW-1:0] wsum(input logic [PW-1:0] a,
                                          input logic [PW-1:0] b,
                                          input logic [PW-1:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  logic [PW-1:0] upper_mem  [MAX_WIDTH];
  logic [PW-1:0] middle_mem [MAX_WIDTH];

  // Read stage.
  logic          rd_valid;
  sgm_pkg::op_t  rd_op;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_upper;
  logic [PW-1:0] rd_middle;
  logic          fwd;
  logic [PW-1:0] fwd_upper;
  logic [PW-1:0] fwd_middle;

  // Window: the two older columns.
  pcol_t win_l;
  pcol_t win_c;

  logic [PW-1:0]        top_raw;
  logic [PW-1:0]        mid_raw;
  pcol_t                new_col;
  pcol_t                right;
  logic signed [GW-1:0] gx;
  logic signed [GW-1:0] gy;

  // Gradient, square and sum stages.
  logic                         g_valid;
  logic signed [GW-1:0]         gx_q;
  logic signed [GW-1:0]         gy_q;
  sgm_pkg::res_tag_t            g_tag;
  logic signed [2*GW-1:0]       prod_x;
  logic signed [2*GW-1:0]       prod_y;
  logic                         sq_valid;
  logic [sgm_pkg::SQ_W-1:0]     sq_x;
  logic [sgm_pkg::SQ_W-1:0]     sq_y;
  sgm_pkg::res_tag_t            sq_tag;
  logic                         s_valid;
  logic [sgm_pkg::SUM_W-1:0]    s_sum;
  sgm_pkg::res_tag_t            s_tag;
  logic [sgm_pkg::MAG_W-1:0]    root;
  sgm_pkg::res_tag_t            root_tag;

  assign op_pop = op_valid && credit_ok;

  // The line stores are read when an item enters and written in the following cycle.
  always_ff @(posedge clk) begin
    if (op_pop) begin
      rd_upper  <= upper_mem[op_addr];
      rd_middle <= middle_mem[op_addr];
    end
    if (rd_valid && rd_op.shift) begin
      upper_mem[rd_addr]  <= mid_raw;
      middle_mem[rd_addr] <= rd_op.bot;
    end
  end

  // With a one-pixel row the next item reads the entry being written; forward it.
  always_ff @(posedge clk) begin
    if (op_pop) begin
      rd_op      <= op;
      rd_addr    <= op_addr;
      fwd        <= rd_valid && rd_op.shift && (op_addr == rd_addr);
      fwd_upper  <= mid_raw;
      fwd_middle <= rd_op.bot;
    end
  end

  always_comb begin
    top_raw     = fwd ? fwd_upper : rd_upper;
    mid_raw     = fwd ? fwd_middle : rd_middle;
    new_col.top = rd_op.top_en ? top_raw : '0;
    new_col.mid = rd_op.mid_en ? mid_raw : '0;
    new_col.bot = rd_op.bot;
    // The end-of-row result sees zero padding on its right.
    right = rd_op.row_end ? '0 : new_col;
    gx = $signed({1'b0, wsum(win_l.top, win_l.mid, win_l.bot)})
       - $signed({1'b0, wsum(right.top, right.mid, right.bot)});
    gy = $signed({1'b0, wsum(win_l.top, win_c.top, right.top)})
       - $signed({1'b0, wsum(win_l.bot, win_c.bot, right.bot)});
    prod_x = gx_q * gx_q;
    prod_y = gy_q * gy_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      win_l    <= '0;
      win_c    <= '0;
      g_valid  <= 1'b0;
      sq_valid <= 1'b0;
      s_valid  <= 1'b0;
    end else begin
      rd_valid <= op_pop;
      if (rd_valid) begin
        win_l <= rd_op.win_clear ? '0 : win_c;
        win_c <= rd_op.shift ? new_col : '0;
      end
      g_valid  <= rd_valid && (rd_op.row_end || rd_op.mid_res);
      sq_valid <= g_valid;
      s_valid  <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    gx_q             <= gx;
    gy_q             <= gy;
    g_tag.row_last   <= rd_op.row_end;
    g_tag.frame_last <= rd_op.row_end && rd_op.frame_end;
    sq_x             <= prod_x[sgm_pkg::SQ_W-1:0];
    sq_y             <= prod_y[sgm_pkg::SQ_W-1:0];
    sq_tag           <= g_tag;
    s_sum            <= {1'b0, sq_x} + {1'b0, sq_y};
    s_tag            <= sq_tag;
  end

  sgm_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .radicand  (s_sum),
    .in_tag    (s_tag),
    .out_valid (res_valid),
    .root      (root),
    .out_tag   (root_tag)
  );

  assign res.magnitude  = root;
  assign res.row_last   = root_tag.row_last;
  assign res.frame_last = root_tag.frame_last;

endmodule

[hw/rtl/sobel_gradient_magnitude.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude
// 3x3 Sobel edge strength over a raster stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Pixels enter on the sample channel (sample_valid, sample_stall, sample) in
// raster order. A sample item with cmd set is a flush item: it advances the
// position without a pixel. After the last pixel of a frame, frame_width + 1
// flush items drain the final results; the item after that starts a new frame.
// Results leave on the result channel (result_valid, result_stall, result):
// one per pixel, with row_last and frame_last marking the ends of rows and of
// the frame. A pixel's result is caused by the item frame_width + 1 places later.
// The front end keeps the position and classifies each item into a four-entry
// queue. The back end takes one item per clock while it has result credit: it
// reads both line stores at the item's column and writes them back in the next
// cycle, so the line store port sets the rate of one item per clock. Results
// pass the gradient, square, sum and root stages and wait in a 32-entry queue.
// When the receiver stalls, the back end stops taking items once the result
// queue has no room for what is in flight, and sample_stall rises when the item
// queue fills. Reset empties both queues, sets both frame registers to 1024 and
// returns the position to the start of a frame. Frame registers are written on
// cfg_we with cfg_index 0 for the width and 1 for the height.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH  = sgm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  sgm_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output sgm_pkg::result_t              result
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int OP_W   = $bits(sgm_pkg::op_t) + AW;
  localparam int RES_W  = $bits(sgm_pkg::result_t);
  localparam int OCNT_W = $clog2(sgm_pkg::OUT_DEPTH + 1);

  logic              accept;
  sgm_pkg::op_t      fr_op;
  logic [AW-1:0]     fr_addr;
  logic              op_full;
  logic              op_empty;
  logic [OP_W-1:0]   head;
  sgm_pkg::op_t      head_op;
  logic [AW-1:0]     head_addr;
  logic              op_pop;
  logic              pop_res;
  logic              credit_ok;
  logic              bk_valid;
  sgm_pkg::result_t  bk_res;
  logic              out_empty;
  logic              out_pop;
  logic [RES_W-1:0]  out_data;
  logic [OCNT_W-1:0] out_count;
  logic [OCNT_W-1:0] inflight;
  logic [OCNT_W-1:0] inflight_next;
  logic [OCNT_W:0]   committed;

  // An item is taken whenever the item queue has room.
  assign sample_stall = op_full;
  assign accept       = sample_valid && !sample_stall;

  sgm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (sample),
    .op        (fr_op),
    .op_addr   (fr_addr)
  );

  sgm_fifo #(
    .WIDTH (OP_W),
    .DEPTH (sgm_pkg::OP_DEPTH)
  ) u_op_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({fr_op, fr_addr}),
    .pop       (op_pop),
    .pop_data  (head),
    .count     (),
    .full      (op_full),
    .empty     (op_empty)
  );

  assign head_op   = sgm_pkg::op_t'(head[OP_W-1:AW]);
  assign head_addr = head[AW-1:0];

  // Results in the back-end pipeline plus those queued never exceed the
  // result queue, so the back end runs without a stall of its own.
  assign committed = {1'b0, inflight} + {1'b0, out_count};
  assign credit_ok = (committed < (OCNT_W + 1)'(sgm_pkg::OUT_DEPTH));
  assign pop_res   = op_pop && (head_op.row_end || head_op.mid_res);

  always_comb begin
    inflight_next = inflight;
    if (pop_res && !bk_valid) begin
      inflight_next = inflight + OCNT_W'(1);
    end else if (!pop_res && bk_valid) begin
      inflight_next = inflight - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  sgm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (!op_empty),
    .op        (head_op),
    .op_addr   (head_addr),
    .credit_ok (credit_ok),
    .op_pop    (op_pop),
    .res_valid (bk_valid),
    .res       (bk_res)
  );

  sgm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (sgm_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (bk_valid),
    .push_data (bk_res),
    .pop       (out_pop),
    .pop_data  (out_data),
    .count     (out_count),
    .full      (),
    .empty     (out_empty)
  );

  assign result_valid = !out_empty;
  assign out_pop      = result_valid && !result_stall;
  assign result       = sgm_pkg::result_t'(out_data);

endmodule

[hw/rtl/sgm_checker.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude port checker
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sgm_port_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_stall,
  input logic             result_valid,
  input logic             result_stall,
  input sgm_pkg::result_t result
);

  // A stalled result stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result behind and room in the item queue.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("queues not empty after reset");

  // The end of a frame is always the end of a row.
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.frame_last || result.row_last))
    else $error("frame_last without row_last");

  // The largest possible magnitude is floor(sqrt(2 * 1020 * 1020)).
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.magnitude <= 11'd1442))
    else $error("magnitude out of range");

endmodule

bind sobel_gradient_magnitude sgm_port_checker u_sgm_checker (.*);

[tb/sgm_checker.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude checker
// Watches the configuration port and both item channels. It keeps its own
// raster position, line stores and 3x3 window, predicts every result and
// compares each result that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module sgm_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          sample_valid,
  input  logic                          sample_stall,
  input  sgm_pkg::sample_t              sample,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  sgm_pkg::result_t              result,
  output int                            mismatch_count,
  output int                            results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_PIXEL    = 1'b0;
  localparam int   LINE_DEPTH   = sgm_pkg::DEF_MAX_WIDTH;
  localparam int   MAX_ROWS     = sgm_pkg::DEF_MAX_HEIGHT;

  logic [sgm_pkg::PIX_W-1:0] upper_line [LINE_DEPTH];
  logic [sgm_pkg::PIX_W-1:0] middle_line [LINE_DEPTH];
  // Rows top, middle, bottom; columns oldest to newest.
  logic [sgm_pkg::PIX_W-1:0] win [3][3];
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic [sgm_pkg::CFG_W-1:0] width_reg;
  logic [sgm_pkg::CFG_W-1:0] height_reg;
  sgm_pkg::result_t          pending_results [$];
  int                        errors;

  function automatic int unsigned usable_dim(input logic [sgm_pkg::CFG_W-1:0] v,
                                             input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // A column index outside 0..2 stands for zero padding.
  function automatic int tap(input int r, input int c);
    return (c >= 0 && c < 3) ? int'(win[r][c]) : 0;
  endfunction

  function automatic logic [sgm_pkg::MAG_W-1:0] sobel_magnitude(input int lc, input int cc,
                                                                input int rc);
    int          gx;
    int          gy;
    int unsigned sq;
    int unsigned root;
    int unsigned trial;
    gx = (tap(0, lc) + 2 * tap(1, lc) + tap(2, lc)) - (tap(0, rc) + 2 * tap(1, rc) + tap(2, rc));
    gy = (tap(0, lc) + 2 * tap(0, cc) + tap(0, rc)) - (tap(2, lc) + 2 * tap(2, cc) + tap(2, rc));
    sq = gx * gx + gy * gy;
    root = 0;
    for (int b = 10; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return root[sgm_pkg::MAG_W-1:0];
  endfunction

  task automatic owe_result(input logic [sgm_pkg::MAG_W-1:0] mag, input logic rl,
                            input logic fl);
    sgm_pkg::result_t r;
    r.magnitude  = mag;
    r.row_last   = rl;
    r.frame_last = fl;
    pending_results.push_back(r);
  endtask

  task automatic advance_raster(input sgm_pkg::sample_t s);
    int unsigned               w;
    int unsigned               h;
    int unsigned               col;
    int unsigned               row;
    int unsigned               a;
    logic [sgm_pkg::PIX_W-1:0] top_px;
    logic [sgm_pkg::PIX_W-1:0] mid_px;
    logic [sgm_pkg::PIX_W-1:0] bot_px;
    w = usable_dim(width_reg, LINE_DEPTH);
    h = usable_dim(height_reg, MAX_ROWS);
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
      row_pos = h + 1;
      col_pos = 0;
    end
    col = col_pos;
    row = row_pos;

    // A new row closes the previous one: its last pixel sees padding on the right.
    if (col == 0) begin
      if (row >= 2) owe_result(sobel_magnitude(1, 2, -1), 1'b1, (row - 2 == h - 1));
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = '0;
    end

    if (row == h + 1) begin
      row_pos = 0;
      col_pos = 0;
      return;
    end

    a = col % LINE_DEPTH;
    bot_px = (s.cmd == CMD_PIXEL && row < h) ? s.pixel : '0;
    top_px = (row >= 2) ? upper_line[a] : '0;
    mid_px = (row >= 1) ? middle_line[a] : '0;
    upper_line[a]  = middle_line[a];
    middle_line[a] = bot_px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top_px;
    win[1][2] = mid_px;
    win[2][2] = bot_px;

    if (col >= 1 && row >= 1) owe_result(sobel_magnitude(0, 1, 2), 1'b0, 1'b0);

    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
    end
  endtask

  function automatic void check_field(input string name, input logic [sgm_pkg::MAG_W-1:0] expv,
                                      input logic [sgm_pkg::MAG_W-1:0] gotv);
    if (gotv !== expv) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, expv, gotv);
    end
  endfunction

  always @(posedge clk) begin
    sgm_pkg::result_t want;
    if (rst) begin
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = sgm_pkg::FRAME_WIDTH_RESET;
      height_reg = sgm_pkg::FRAME_HEIGHT_RESET;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      pending_results.delete();
      errors = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: expected no result, got magnitude %0d", $time,
                   result.magnitude);
        end else begin
          want = pending_results.pop_front();
          check_field("magnitude", want.magnitude, result.magnitude);
          check_field("row_last", sgm_pkg::MAG_W'(want.row_last),
                      sgm_pkg::MAG_W'(result.row_last));
          check_field("frame_last", sgm_pkg::MAG_W'(want.frame_last),
                      sgm_pkg::MAG_W'(result.frame_last));
        end
      end
      if (cfg_we) begin
        if (cfg_index == sgm_pkg::REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == sgm_pkg::REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (sample_valid && !sample_stall) advance_raster(sample);
    end
    mismatch_count <= errors;
    results_owed   <= pending_results.size();
  end

endmodule

[tb/tb_sobel_gradient_magnitude.sv]
// ----------------------------------------------------------------------------
// Sobel gradient magnitude testbench
// Feeds frames of grayscale pixels and flush items through the block under
// bursty input and a stalling receiver, and changes the frame size between
// and inside frames. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_sobel_gradient_magnitude;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_PIXEL     = 1'b0;
  localparam logic CMD_FLUSH     = 1'b1;
  localparam int   MAX_WIDTH     = sgm_pkg::DEF_MAX_WIDTH;
  localparam int   MAX_HEIGHT    = sgm_pkg::DEF_MAX_HEIGHT;
  // Item count at which the random part stops starting new frames.
  localparam int   RANDOM_ITEMS  = 400;
  // A result passes the back-end pipeline and may still sit in the result
  // queue; this covers the whole pipeline with room to spare.
  localparam int   SETTLE_CYCLES = 64;
  // Long enough for the result queue and the item queue to fill completely.
  localparam int   HOLD_CYCLES   = 300;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          cfg_we       = 1'b0;
  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [sgm_pkg::CFG_W-1:0]     cfg_data     = '0;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  sgm_pkg::sample_t              sample       = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  sgm_pkg::result_t              result;

  int   mismatch_count;
  int   results_owed;

  // Register values currently in the block, as written.
  int   cur_w;
  int   cur_h;
  // Items left in the current input burst; zero starts a new burst.
  int   burst_left   = 0;
  // While set, the sender offers items back to back with no gaps.
  bit   steady_feed  = 1'b0;
  // Raised by the stimulus, consumed by the receiver to start its long hold.
  logic hold_armed   = 1'b0;
  int   items_sent   = 0;

  sobel_gradient_magnitude i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  sgm_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: stretches of random length, each with its own stall density,
  // from never stalling to stalling almost always. When armed, it holds off
  // completely for a long count of cycles so that the block backs up.
  initial begin
    int stretch;
    int busy_pct;
    int n;
    forever begin
      stretch = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: busy_pct = 0;
        1: busy_pct = 30;
        2: busy_pct = 60;
        default: busy_pct = 90;
      endcase
      for (n = 0; n < stretch; n++) begin
        if (hold_armed) begin
          hold_armed   <= 1'b0;
          result_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        result_stall <= ($urandom_range(0, 99) < busy_pct);
        @(posedge clk);
      end
    end
  end

  function automatic int usable_dim(input int v, input int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Offers one item and returns at the edge where it is taken. Items come in
  // bursts; between bursts valid drops for a random gap, but not in steady feed.
  task automatic send_item(input logic kind, input logic [sgm_pkg::PIX_W-1:0] px);
    int               gap;
    sgm_pkg::sample_t s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (steady_feed) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 20);
      else gap = $urandom_range(0, 3);
      if (gap != 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s.cmd        = kind;
    s.pixel      = px;
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Stops the input and lets every outstanding result drain. The latency wait
  // also covers items still in flight that produce no result of their own.
  task automatic wait_quiet();
    sample_valid <= 1'b0;
    burst_left = 0;
    do begin
      while (results_owed != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (results_owed != 0);
  endtask

  // Writes both frame registers; only called while the block is quiet.
  task automatic set_frame(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= sgm_pkg::REG_FRAME_WIDTH;
    cfg_data  <= sgm_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_index <= sgm_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= sgm_pkg::CFG_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // One whole frame with random content, followed by its drain items. Inside
  // the frame a flush item turns up now and then; the drain mixes pixel items
  // (which the block must ignore) with flush items. A broken frame is stopped
  // at a random item, gets a new height, and then runs to wherever that new
  // height ends it: either the rest of the resized frame or one item that the
  // block takes as the final drain item.
  task automatic run_frame(input int w_reg, input int h_reg, input bit broken,
                           input bit pressure);
    int                        w;
    int                        h;
    int                        total;
    int                        cut;
    int                        i;
    logic                      kind;
    logic [sgm_pkg::PIX_W-1:0] px;
    if (w_reg != cur_w || h_reg != cur_h || pressure) begin
      wait_quiet();
      set_frame(w_reg, h_reg);
    end
    if (pressure) hold_armed <= 1'b1;
    steady_feed = pressure;
    w = usable_dim(w_reg, MAX_WIDTH);
    h = usable_dim(h_reg, MAX_HEIGHT);
    total = w * (h + 1) + 1;
    cut = broken ? $urandom_range(1, total - 1) : total;
    for (i = 0; i < total; i++) begin
      if (i == cut) begin
        wait_quiet();
        h_reg = $urandom_range(1, 8);
        set_frame(w_reg, h_reg);
        h = h_reg;
        total = (i <= w * (h + 1)) ? w * (h + 1) + 1 : i + 1;
      end
      if (i < w * h) kind = ($urandom_range(0, 9) == 0) ? CMD_FLUSH : CMD_PIXEL;
      else kind = ($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH;
      // Lean toward the extremes so that large gradients show up often.
      case ($urandom_range(0, 3))
        0: px = '0;
        1: px = '1;
        default: px = sgm_pkg::PIX_W'($urandom_range(0, 255));
      endcase
      send_item(kind, px);
    end
    items_sent += total;
    steady_feed = 1'b0;
  endtask

  initial begin
    int w_reg;
    int h_reg;
    bit broken;
    cur_w = int'(sgm_pkg::FRAME_WIDTH_RESET);
    cur_h = int'(sgm_pkg::FRAME_HEIGHT_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame laid out so that the centre sees full white on its left and
    // black on its right, white above and black below: the largest x gradient.
    // A flush item inside the frame stands in for a black pixel.
    set_frame(3, 3);
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_PIXEL, 8'd0);
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_FLUSH, 8'd0);
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_PIXEL, 8'd0);
    send_item(CMD_PIXEL, 8'd0);
    // Drain: the pixel items here must be taken as zero padding.
    send_item(CMD_PIXEL, 8'd255);
    send_item(CMD_FLUSH, 8'd0);
    send_item(CMD_PIXEL, 8'd128);
    send_item(CMD_FLUSH, 8'd0);

    // Width shrinks mid-row: the position wraps to the next row. Later the
    // height shrinks below the current row, so the next item ends the frame.
    wait_quiet();
    set_frame(4, 4);
    repeat (6) send_item(CMD_PIXEL, sgm_pkg::PIX_W'($urandom_range(0, 255)));
    wait_quiet();
    set_frame(2, 4);
    repeat (3) send_item(CMD_PIXEL, sgm_pkg::PIX_W'($urandom_range(0, 255)));
    wait_quiet();
    set_frame(2, 1);
    send_item(CMD_PIXEL, 8'd255);

    // A mid-sized frame fed without gaps while the receiver holds off.
    run_frame(20, 12, 1'b0, 1'b1);

    // Mostly small frames; half of them keep the previous size and follow
    // straight on without a pause.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      end else begin
        w_reg = cur_w;
        h_reg = cur_h;
      end
      broken = ($urandom_range(0, 7) == 0);
      run_frame(w_reg, h_reg, broken, 1'b0);
    end

    // Size extremes: zero in either register acts as one.
    run_frame(0, 0, 1'b0, 1'b0);
    run_frame(0, 3, 1'b0, 1'b0);
    run_frame(5, 0, 1'b0, 1'b0);

    wait_quiet();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
